// ===== rtl/cbsi_pkg.sv =====
// shared types and constants of the cartridge bank switch and irq block
`default_nettype none
package cbsi_pkg;

  localparam int DATA_W  = 8;
  localparam int CNT_W   = 16;
  localparam int MOD_W   = 11;
  localparam int DIGIT_W = 2;
  localparam int MOD_STEPS = DATA_W;
  localparam int IRQ_STEPS = CNT_W / DIGIT_W;

  localparam logic [CNT_W-1:0] IRQ_STEP = 16'd114;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    REG_PRG_BASE = 4'd8,
    REG_MIRROR   = 4'd9,
    REG_IRQ_CTRL = 4'd10,
    REG_LATCH_LO = 4'd11,
    REG_LATCH_HI = 4'd12
  } reg_code_t;

  typedef enum logic {
    CFG_CHR_UNITS = 1'b0,
    CFG_PRG_UNITS = 1'b1
  } cfg_code_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] value;
    logic [MOD_W-1:0]  modulus;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } irq_req_t;

  typedef struct packed {
    logic             done;
    logic             expire;
    logic [CNT_W-1:0] count;
  } irq_rsp_t;

  // two-bit digit of the per-scanline decrement
  function automatic logic [DIGIT_W-1:0] step_digit(input logic [2:0] idx);
    step_digit = IRQ_STEP[{idx, 1'b0} +: DIGIT_W];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cbsi_mod_serial.sv =====
// bit-serial restoring remainder of a byte by a page count
`default_nettype none
module cbsi_mod_serial (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cbsi_pkg::mod_req_t req,
  output cbsi_pkg::mod_rsp_t     rsp
);

  logic [cbsi_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [cbsi_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [cbsi_pkg::MOD_W-1:0]  mod_r, mod_nxt;
  logic [2:0]                  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [cbsi_pkg::DATA_W:0]   trial;
  logic [cbsi_pkg::MOD_W-1:0]  trial_ext;

  always_comb begin
    trial     = {rem_r, val_r[cbsi_pkg::DATA_W-1]};
    trial_ext = {{(cbsi_pkg::MOD_W-cbsi_pkg::DATA_W-1){1'b0}}, trial};
    val_nxt   = val_r;
    rem_nxt   = rem_r;
    mod_nxt   = mod_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      val_nxt  = req.value;
      rem_nxt  = '0;
      mod_nxt  = req.modulus;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[cbsi_pkg::DATA_W-2:0], 1'b0};
      // a zero modulus leaves the byte unreduced
      if (mod_r != '0 && trial_ext >= mod_r) begin
        rem_nxt = trial[cbsi_pkg::DATA_W-1:0] - mod_r[cbsi_pkg::DATA_W-1:0];
      end else begin
        rem_nxt = trial[cbsi_pkg::DATA_W-1:0];
      end
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'(cbsi_pkg::MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/cbsi_irq_serial.sv =====
// digit-serial scanline counter decrement with expiry detection
`default_nettype none
module cbsi_irq_serial (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cbsi_pkg::irq_req_t req,
  output cbsi_pkg::irq_rsp_t     rsp
);

  logic [cbsi_pkg::CNT_W-1:0] src_r, src_nxt;
  logic [cbsi_pkg::CNT_W-1:0] res_r, res_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic                       borrow_r, borrow_nxt;
  logic                       nz_r, nz_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [cbsi_pkg::DIGIT_W:0] diff;

  always_comb begin
    diff = {1'b0, src_r[cbsi_pkg::DIGIT_W-1:0]}
         - {1'b0, cbsi_pkg::step_digit(cnt_r)}
         - {{cbsi_pkg::DIGIT_W{1'b0}}, borrow_r};
    src_nxt    = src_r;
    res_nxt    = res_r;
    cnt_nxt    = cnt_r;
    borrow_nxt = borrow_r;
    nz_nxt     = nz_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      src_nxt    = req.count;
      cnt_nxt    = '0;
      borrow_nxt = 1'b0;
      nz_nxt     = 1'b0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      // lsb digit first, difference digits enter from the top
      src_nxt    = {{cbsi_pkg::DIGIT_W{1'b0}}, src_r[cbsi_pkg::CNT_W-1:cbsi_pkg::DIGIT_W]};
      res_nxt    = {diff[cbsi_pkg::DIGIT_W-1:0], res_r[cbsi_pkg::CNT_W-1:cbsi_pkg::DIGIT_W]};
      borrow_nxt = diff[cbsi_pkg::DIGIT_W];
      nz_nxt     = nz_r | (diff[cbsi_pkg::DIGIT_W-1:0] != '0);
      cnt_nxt    = cnt_r + 3'd1;
      if (cnt_r == 3'(cbsi_pkg::IRQ_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r    <= src_nxt;
    res_r    <= res_nxt;
    cnt_r    <= cnt_nxt;
    borrow_r <= borrow_nxt;
    nz_r     <= nz_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // counter at or below the step: borrow out or an exact zero difference
  assign rsp.done   = done_r;
  assign rsp.expire = borrow_r | ~nz_r;
  assign rsp.count  = res_r;

endmodule
`default_nettype wire

// ===== rtl/cartridge_bank_switch_irq.sv =====
// top level of the cartridge bank switch and scanline irq mapper
//
//  channel   dir  handshake                  payload
//  in_*      in   in_tvalid / in_tready      tdata: reg_select, write_byte; tuser: opcode
//  out_*     out  out_tvalid / out_tready    tdata: chr_page_0..7, prg_page_base,
//                                            mirror_mode, irq_pulse
//  cfg_*     in   cfg_wr_en                  cfg_index, cfg_wdata
//
// page writes run the bit-serial remainder unit, then pass through issue, done and
// output load; a new beat is accepted only once the last one has left the finish state
// an enabled scanline tick runs the 2-bit digit-serial subtract in the same way
// other writes and disabled ticks go straight to the finish state
// synchronous reset clears bank state, counter and latch; rom sizes go to one unit
// one beat in flight; a stalled out_tready holds the next result in the finish state
`default_nettype none
module cartridge_bank_switch_irq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [3:0] reg_select, [11:4] write_byte, rest zero
  input  wire logic [0:0]  in_tuser,   // [0] opcode
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [63:0] chr_page_0..7, [71:64] prg_page_base,
                                       // [73:72] mirror_mode, [74] irq_pulse, rest zero
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_IRQ,
    ST_FIN
  } state_t;

  state_t                     state_r;
  logic [7:0]                 chr_units_r;
  logic [7:0]                 prg_units_r;
  logic [7:0]                 chr_page_r [8];
  logic [7:0]                 prg_r;
  logic [1:0]                 mirror_r;
  logic                       irq_en_r;
  logic [cbsi_pkg::CNT_W-1:0] irq_cnt_r;
  logic [cbsi_pkg::CNT_W-1:0] irq_rel_r;
  logic [3:0]                 sel_r;
  logic                       pulse_r;
  logic                       out_valid_r;
  logic [79:0]                out_data_r;

  logic [3:0]         in_sel;
  logic [7:0]         in_byte;
  logic               in_fire;
  logic               in_is_tick;
  logic               out_free;
  cbsi_pkg::mod_req_t mod_req;
  cbsi_pkg::mod_rsp_t mod_rsp;
  cbsi_pkg::irq_req_t irq_req;
  cbsi_pkg::irq_rsp_t irq_rsp;

  assign in_sel     = in_tdata[3:0];
  assign in_byte    = in_tdata[11:4];
  assign in_is_tick = (in_tuser[0] == cbsi_pkg::OP_TICK);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;

  // page writes go to the remainder unit; program page uses the doubled byte
  always_comb begin
    mod_req.start = in_fire & ~in_is_tick & (in_sel <= cbsi_pkg::REG_PRG_BASE);
    if (in_sel[3]) begin
      mod_req.value   = {in_byte[6:0], 1'b0};
      mod_req.modulus = {2'b00, prg_units_r, 1'b0};
    end else begin
      mod_req.value   = in_byte;
      mod_req.modulus = {chr_units_r, 3'b000};
    end
  end

  assign irq_req.start = in_fire & in_is_tick & irq_en_r;
  assign irq_req.count = irq_cnt_r;

  cbsi_mod_serial u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  cbsi_irq_serial u_irq (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (irq_req),
    .rsp   (irq_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chr_units_r <= 8'd1;
      prg_units_r <= 8'd1;
      for (int i = 0; i < 8; i++) begin
        chr_page_r[i] <= '0;
      end
      prg_r       <= '0;
      mirror_r    <= '0;
      irq_en_r    <= 1'b0;
      irq_cnt_r   <= '0;
      irq_rel_r   <= '0;
      sel_r       <= '0;
      pulse_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          cbsi_pkg::CFG_CHR_UNITS: chr_units_r <= cfg_wdata;
          cbsi_pkg::CFG_PRG_UNITS: prg_units_r <= cfg_wdata;
          default: ;
        endcase
      end

      // a taken result empties the slot unless the finish state refills it
      if (out_valid_r && out_tready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sel_r   <= in_sel;
            pulse_r <= 1'b0;
            if (in_is_tick) begin
              // disabled counter: nothing moves
              state_r <= irq_en_r ? ST_IRQ : ST_FIN;
            end else if (in_sel <= cbsi_pkg::REG_PRG_BASE) begin
              state_r <= ST_MOD;
            end else begin
              case (in_sel)
                cbsi_pkg::REG_MIRROR:   mirror_r <= in_byte[1:0] ^ 2'b01;
                cbsi_pkg::REG_IRQ_CTRL: begin
                  irq_en_r  <= in_byte[0];
                  irq_cnt_r <= irq_rel_r;
                end
                cbsi_pkg::REG_LATCH_LO: irq_rel_r[7:0]  <= in_byte;
                cbsi_pkg::REG_LATCH_HI: irq_rel_r[15:8] <= in_byte;
                default: ;
              endcase
              state_r <= ST_FIN;
            end
          end
        end
        ST_MOD: begin
          if (mod_rsp.done) begin
            if (sel_r[3]) begin
              prg_r <= mod_rsp.rem;
            end else begin
              chr_page_r[sel_r[2:0]] <= mod_rsp.rem;
            end
            state_r <= ST_FIN;
          end
        end
        ST_IRQ: begin
          if (irq_rsp.done) begin
            if (irq_rsp.expire) begin
              irq_cnt_r <= '0;
              irq_en_r  <= 1'b0;
              pulse_r   <= 1'b1;
            end else begin
              irq_cnt_r <= irq_rsp.count;
            end
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // snapshot the bank state once the output slot is free
          if (out_free) begin
            out_data_r <= {5'b00000, pulse_r, mirror_r, prg_r,
                           chr_page_r[7], chr_page_r[6], chr_page_r[5], chr_page_r[4],
                           chr_page_r[3], chr_page_r[2], chr_page_r[1], chr_page_r[0]};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== test/tb_cartridge_bank_switch_irq.sv =====
// self-checking testbench for the cartridge bank switch and scanline irq mapper
module tb_cartridge_bank_switch_irq;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int RANDOM_BEATS    = 1880;
  localparam int RANDOM_PHASES   = 8;
  localparam int WATCHDOG_CYCLES = 4000;  // longest gap, stall and block time, several times over
  localparam int SETTLE_CYCLES   = 24;    // settle time after the final drain
  localparam int MAX_IRQ_TICKS   = 80;

  // mapper constants as the predictor sees them
  localparam int              CHR_WINDOWS        = 8;
  localparam logic [15:0]     SCANLINE_DECREMENT = 16'd114;
  localparam logic [3:0]      REG_SPARE_A        = 4'd13;
  localparam logic [3:0]      REG_SPARE_B        = 4'd14;
  localparam logic [3:0]      REG_SPARE_C        = 4'd15;

  // result beat laid out exactly as out_tdata, lowest field last
  typedef struct packed {
    logic [4:0]      pad;
    logic            irq;
    logic [1:0]      mirror;
    logic [7:0]      prg;
    logic [7:0][7:0] chr;
  } bank_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [3:0] reg_select, [11:4] write_byte, rest zero
  logic [0:0]  in_tuser = '0;   // [0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // [63:0] chr_page_0..7, [71:64] prg_page_base,
                                // [73:72] mirror_mode, [74] irq_pulse, rest zero
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  // predictor copy of the mapper state and rom sizes
  logic [7:0]            chr_units = 8'd1;
  logic [7:0]            prg_units = 8'd1;
  logic [7:0][7:0]       chr_page = '0;
  logic [7:0]            prg_page = '0;
  logic [1:0]            mirror_sel = '0;
  logic                  irq_armed = 1'b0;
  logic [15:0]           irq_count = '0;
  logic [15:0]           irq_latch = '0;

  // bank views still owed by the block, oldest first
  bank_view_t expected_views[$];

  int  errors = 0;
  int  beats_sent = 0;
  int  quiet_cycles = 0;
  int  ready_hold = 0;
  bit  no_idle = 1'b0;  // when set, neither side inserts gaps
  bank_view_t want_view;
  bank_view_t seen_view;

  cartridge_bank_switch_irq i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // page number folded into the rom, a zero-sized rom leaves it as written
  function automatic logic [7:0] fold_page(logic [7:0] value, int page_count);
    if (page_count == 0) return value;
    return 8'(int'(value) % page_count);
  endfunction

  // apply one accepted beat to the predictor and queue the bank view it yields
  task automatic predict_beat(cbsi_pkg::opcode_t op, logic [3:0] sel, logic [7:0] data);
    bank_view_t view;
    view = '0;
    if (op == cbsi_pkg::OP_WRITE) begin
      if (sel < CHR_WINDOWS) begin
        chr_page[sel[2:0]] = fold_page(data, int'(chr_units) * 8);
      end else begin
        case (sel)
          cbsi_pkg::REG_PRG_BASE: prg_page = fold_page({data[6:0], 1'b0}, int'(prg_units) * 2);
          cbsi_pkg::REG_MIRROR:   mirror_sel = data[1:0] ^ 2'b01;
          cbsi_pkg::REG_IRQ_CTRL: begin
            irq_armed = data[0];
            irq_count = irq_latch;
          end
          cbsi_pkg::REG_LATCH_LO: irq_latch[7:0] = data;
          cbsi_pkg::REG_LATCH_HI: irq_latch[15:8] = data;
          default: ;  // spare registers are ignored
        endcase
      end
    end else if (irq_armed) begin
      // counter at or under one scanline step fires and disarms
      if (irq_count <= SCANLINE_DECREMENT) begin
        irq_count = '0;
        irq_armed = 1'b0;
        view.irq  = 1'b1;
      end else begin
        irq_count = irq_count - SCANLINE_DECREMENT;
      end
    end
    view.chr    = chr_page;
    view.prg    = prg_page;
    view.mirror = mirror_sel;
    expected_views.push_back(view);
  endtask

  // offer one beat; tvalid stays high into the next call unless a gap is drawn
  task automatic send_beat(cbsi_pkg::opcode_t op, logic [3:0] sel, logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, data, sel};
    do @(posedge clk); while (!in_tready);
    predict_beat(op, sel, data);
    beats_sent++;
  endtask

  // stop sending and hold off until every owed bank view has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
  endtask

  // both rom sizes, only while the block is idle
  task automatic set_rom_sizes(logic [7:0] chr, logic [7:0] prg);
    cfg_wr_en <= 1'b1;
    cfg_index <= cbsi_pkg::CFG_CHR_UNITS;
    cfg_wdata <= chr;
    @(posedge clk);
    cfg_index <= cbsi_pkg::CFG_PRG_UNITS;
    cfg_wdata <= prg;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chr_units = chr;
    prg_units = prg;
  endtask

  // fresh out of reset: all zero, a disarmed tick and spare writes change nothing
  task automatic test_reset_view();
    send_beat(cbsi_pkg::OP_TICK, 4'h0, 8'h00);
    send_beat(cbsi_pkg::OP_WRITE, REG_SPARE_A, 8'hff);
    send_beat(cbsi_pkg::OP_WRITE, REG_SPARE_B, 8'hff);
    send_beat(cbsi_pkg::OP_WRITE, REG_SPARE_C, 8'hff);
  endtask

  // bank, program and mirror writes at the reset rom sizes
  task automatic test_bank_writes();
    send_beat(cbsi_pkg::OP_WRITE, 4'd0, 8'hff);          // folds to 7 with one chr unit
    send_beat(cbsi_pkg::OP_WRITE, 4'd7, 8'h00);
    send_beat(cbsi_pkg::OP_WRITE, 4'd3, 8'haa);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_PRG_BASE, 8'hff);  // doubled byte drops its top bit
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_PRG_BASE, 8'h01);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_MIRROR, 8'h00);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_MIRROR, 8'h03);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_MIRROR, 8'hfe);
  endtask

  // counter exactly one step fires at once, one more takes two ticks
  task automatic test_irq_boundary();
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_LATCH_LO, 8'h72);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_LATCH_HI, 8'h00);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_IRQ_CTRL, 8'h01);
    send_beat(cbsi_pkg::OP_TICK, 4'hf, 8'hff);
    send_beat(cbsi_pkg::OP_TICK, 4'h5, 8'h5a);           // already disarmed, no pulse
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_LATCH_LO, 8'h73);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_IRQ_CTRL, 8'hff);
    send_beat(cbsi_pkg::OP_TICK, 4'ha, 8'h00);
    send_beat(cbsi_pkg::OP_TICK, 4'h0, 8'hff);
  endtask

  // zero-sized roms keep pages unreduced
  task automatic test_zero_sizes();
    wait_for_results();
    set_rom_sizes(8'd0, 8'd0);
    send_beat(cbsi_pkg::OP_WRITE, 4'd1, 8'hff);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_PRG_BASE, 8'hff);
  endtask

  // largest roms
  task automatic test_full_sizes();
    wait_for_results();
    set_rom_sizes(8'd255, 8'd255);
    send_beat(cbsi_pkg::OP_WRITE, 4'd2, 8'hfb);
    send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_PRG_BASE, 8'h7f);
  endtask

  // phases of random traffic, each at its own rom sizes, drained in between
  task automatic test_random_traffic();
    int phase;
    int phase_end;
    int roll;
    int ticks;
    logic [7:0] chr;
    logic [7:0] prg;
    logic [7:0] latch_hi;
    logic [7:0] ctrl;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      case (phase)
        0: begin chr = 8'd1;   prg = 8'd1;   end
        1: begin chr = 8'd0;   prg = 8'd255; end
        2: begin chr = 8'd255; prg = 8'd0;   end
        3: begin chr = 8'd255; prg = 8'd255; end
        default: begin
          // small sizes make the fold bite on most bytes
          chr = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(1, 255));
          prg = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, 255));
        end
      endcase
      set_rom_sizes(chr, prg);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_end = beats_sent + RANDOM_BEATS / RANDOM_PHASES;
      while (beats_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          // arm the counter and tick it down to its pulse, with stray writes mixed in
          if ($urandom_range(0, 3) != 0) begin
            roll = $urandom_range(0, 99);
            latch_hi = (roll < 70) ? 8'd0 :
                       (roll < 92) ? 8'($urandom_range(1, 2)) : 8'($urandom_range(3, 8));
            send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_LATCH_LO, 8'($urandom));
            send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_LATCH_HI, latch_hi);
          end
          ctrl = 8'($urandom);
          if ($urandom_range(0, 9) != 0) ctrl[0] = 1'b1;
          send_beat(cbsi_pkg::OP_WRITE, cbsi_pkg::REG_IRQ_CTRL, ctrl);
          ticks = 0;
          while (irq_armed && ticks < MAX_IRQ_TICKS) begin
            if ($urandom_range(0, 7) == 0) begin
              send_beat(cbsi_pkg::OP_WRITE, 4'($urandom), 8'($urandom));
            end else begin
              send_beat(cbsi_pkg::OP_TICK, 4'($urandom), 8'($urandom));
              ticks++;
            end
          end
          send_beat(cbsi_pkg::OP_TICK, 4'($urandom), 8'($urandom));
        end else if (roll < 80) begin
          // bank, program and mirror writes
          send_beat(cbsi_pkg::OP_WRITE, 4'($urandom_range(0, 9)), 8'($urandom));
        end else begin
          // anything at all
          send_beat(cbsi_pkg::opcode_t'($urandom_range(0, 1)), 4'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver: random stalls that can land on any phase of a beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, seen);
      errors++;
    end
  endfunction

  // compare every accepted result beat with the oldest owed view
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_views.size() == 0) begin
        $display("%0t ns: result beat expected none actual %h", $time, out_tdata);
        errors++;
      end else begin
        want_view = expected_views.pop_front();
        seen_view = out_tdata;
        for (int w = 0; w < CHR_WINDOWS; w++) begin
          check_field($sformatf("chr_page_%0d", w), want_view.chr[w], seen_view.chr[w]);
        end
        check_field("prg_page_base", want_view.prg, seen_view.prg);
        check_field("mirror_mode", 8'(want_view.mirror), 8'(seen_view.mirror));
        check_field("irq_pulse", 8'(want_view.irq), 8'(seen_view.irq));
        check_field("tdata padding", 8'(want_view.pad), 8'(seen_view.pad));
      end
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_bank_writes();
    test_irq_boundary();
    test_zero_sizes();
    test_full_sizes();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_views.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cbsi_pkg.sv
rtl/cbsi_mod_serial.sv
rtl/cbsi_irq_serial.sv
rtl/cartridge_bank_switch_irq.sv
test/tb_cartridge_bank_switch_irq.sv
